[src/esc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned TFINE_W     = 24;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_LAST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_TRIM        = 3'd4;

	typedef struct packed {
		logic signed [TFINE_W-1:0] t_fine;
		logic [19:0]               adc_p;
		logic [15:0]               adc_h;
	} esc_item_t;

endpackage
`default_nettype wire

[src/esc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_front
// Input stage: accepts raw samples and forms the fine temperature in a
// three-stage pipeline before handing each sample to the queue.
// ----------------------------------------------------------------------------
module esc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [19:0]         raw_pressure,
	input  wire logic [19:0]         raw_temperature,
	input  wire logic [15:0]         raw_humidity,
	input  wire logic [47:0]         temp_trim,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output esc_pkg::esc_item_t       push_item
);

	logic v1_q, v2_q, v3_q;
	logic adv;

	logic [19:0] adc_t_s1, adc_p_s1, adc_p_s2, adc_p_s3;
	logic [15:0] adc_h_s1, adc_h_s2, adc_h_s3;
	logic signed [34:0] va_p_s2;
	logic [20:0]        ddsh_s2;
	logic signed [23:0] va_s3;
	logic signed [37:0] vb_p_s3;

	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic signed [18:0] a_t;
	logic signed [17:0] d;
	logic signed [34:0] va_p;
	logic signed [35:0] dd;
	logic signed [37:0] vb_p;
	logic signed [23:0] vb;
	logic signed [23:0] t_fine;

	assign adv      = !v3_q || push_ready;
	assign in_ready = adv;

	always_comb begin
		t1     = temp_trim[15:0];
		t2     = $signed(temp_trim[31:16]);
		t3     = $signed(temp_trim[47:32]);
		a_t    = $signed({2'b00, adc_t_s1[19:3]}) - $signed({1'b0, t1, 1'b0});
		d      = $signed({2'b00, adc_t_s1[19:4]}) - $signed({2'b00, t1});
		va_p   = a_t * t2;
		dd     = d * d;
		vb_p   = $signed({1'b0, ddsh_s2}) * t3;
		vb     = vb_p_s3[37:14];
		t_fine = va_s3 + vb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= in_valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adc_t_s1 <= raw_temperature;
			adc_p_s1 <= raw_pressure;
			adc_h_s1 <= raw_humidity;
			adc_p_s2 <= adc_p_s1;
			adc_h_s2 <= adc_h_s1;
			va_p_s2  <= va_p;
			ddsh_s2  <= dd[32:12];
			adc_p_s3 <= adc_p_s2;
			adc_h_s3 <= adc_h_s2;
			va_s3    <= va_p_s2[34:11];
			vb_p_s3  <= vb_p;
		end
	end

	assign push_valid = v3_q;

	always_comb begin
		push_item.t_fine = t_fine;
		push_item.adc_p  = adc_p_s3;
		push_item.adc_h  = adc_h_s3;
	end

endmodule
`default_nettype wire

[src/esc_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_fifo
// Short queue of fine-temperature samples between the front and back parts.
// ----------------------------------------------------------------------------
module esc_fifo #(
	parameter int unsigned DEPTH = esc_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire esc_pkg::esc_item_t  push_item,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output esc_pkg::esc_item_t       pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	esc_pkg::esc_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

[src/esc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_mul
// Wrapping 64 x 64 multiplier built from one 32 x 32 multiplier that forms
// the partial products in turn; the low 64 bits of the product are returned.
// ----------------------------------------------------------------------------
module esc_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  ph_q;
	logic        busy_q, done_q;
	logic [31:0] ma, mb;
	logic [63:0] prod;

	always_comb begin
		case (ph_q)
			2'd0: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
			2'd1: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
			default: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
		endcase
		prod = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				ph_q   <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ph_q == 2'd0) begin
					acc_q <= prod;
				end else begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				end
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				ph_q <= ph_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule
`default_nettype wire

[src/esc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_div
// Signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module esc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic             done,
	output logic [63:0]      quo
);

	logic [63:0] den_q, quo_q;
	logic [64:0] rem_q, rem_sh, diff;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q, done_q, qbit;

	always_comb begin
		rem_sh = {rem_q[63:0], quo_q[63]};
		diff   = rem_sh - {1'b0, den_q};
		qbit   = !diff[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			den_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q  <= num[63] ^ den[63];
				quo_q  <= num[63] ? -num : num;
				den_q  <= den[63] ? -den : den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? diff : rem_sh;
				quo_q <= {quo_q[62:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -quo_q : quo_q;

endmodule
`default_nettype wire

[src/esc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_back
// Sequencer that runs the pressure and humidity compensation of one sample
// on a shared multiplier and a divider, and holds the result register.
// ----------------------------------------------------------------------------
module esc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pop_valid,
	output logic                     pop_ready,
	input  wire esc_pkg::esc_item_t  pop_item,
	input  wire logic [63:0]         press_trim_low,
	input  wire logic [63:0]         press_trim_high,
	input  wire logic [15:0]         press_trim_last,
	input  wire logic [63:0]         hum_trim,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       temperature_centi,
	output logic signed [31:0]       pressure_q24_8,
	output logic [16:0]              humidity_q22_10,
	output logic                     pressure_valid
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ISSUE = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		SP_XX, SP_B6, SP_X5, SP_X3, SP_X2, SP_A, SP_NUM, SP_E1, SP_E2, SP_F,
		SH_M, SH_B0, SH_C0, SH_B1, SH_B2, SH_V, SH_EE, SH_E1
	} step_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	state_t st_q;
	step_t  step_q;

	logic signed [23:0] t_fine_q;
	logic [19:0]        adc_p_q;
	logic [15:0]        adc_h_q;
	logic [63:0]        xx_q, b_q, tmp_q, num_q;
	logic signed [63:0] a_q, q_q, e_q;
	logic signed [31:0] pres_q, ha_q, hb_q, hc_q, hv_q, he_q;
	logic [16:0]        hum_q;
	logic               pvalid_q, div_start_q;

	logic               out_valid_q, out_pvalid_q;
	logic signed [31:0] out_temp_q, out_pres_q;
	logic [16:0]        out_hum_q;

	logic        mul_start, mul_done, div_done;
	logic [63:0] opa, opb, mul_res, div_quo;

	logic [63:0]        p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0]        h1, h2, h3, h4, h5, h6;
	logic signed [63:0] x_p, res_s, a_nx, qs, f_v, s_v, pf;
	logic signed [31:0] hx, r32, a32, he_nx, v32, sat32;
	logic [20:0]        pd;
	logic [16:0]        hum_nx;
	logic signed [26:0] tf_e, tf5;
	logic signed [31:0] temp_nx;
	logic               out_load;

	always_comb begin
		p1 = {48'b0, press_trim_low[15:0]};
		p2 = sx16(press_trim_low[31:16]);
		p3 = sx16(press_trim_low[47:32]);
		p4 = sx16(press_trim_low[63:48]);
		p5 = sx16(press_trim_high[15:0]);
		p6 = sx16(press_trim_high[31:16]);
		p7 = sx16(press_trim_high[47:32]);
		p8 = sx16(press_trim_high[63:48]);
		p9 = sx16(press_trim_last);
		h1 = {56'b0, hum_trim[7:0]};
		h2 = sx16(hum_trim[23:8]);
		h3 = {56'b0, hum_trim[31:24]};
		h4 = {{52{hum_trim[43]}}, hum_trim[43:32]};
		h5 = {{52{hum_trim[55]}}, hum_trim[55:44]};
		h6 = {{56{hum_trim[63]}}, hum_trim[63:56]};

		x_p = {{40{t_fine_q[23]}}, t_fine_q} - 64'sd128000;
		hx  = {{8{t_fine_q[23]}}, t_fine_q} - 32'sd76800;
		pd  = 21'd1048576 - {1'b0, adc_p_q};
		qs  = q_q >>> 13;

		case (step_q)
			SP_XX: begin
				opa = x_p;
				opb = x_p;
			end
			SP_B6: begin
				opa = xx_q;
				opb = p6;
			end
			SP_X5: begin
				opa = x_p;
				opb = p5;
			end
			SP_X3: begin
				opa = xx_q;
				opb = p3;
			end
			SP_X2: begin
				opa = x_p;
				opb = p2;
			end
			SP_A: begin
				opa = tmp_q + 64'h0000_8000_0000_0000;
				opb = p1;
			end
			SP_NUM: begin
				opa = ({43'b0, pd} << 31) - b_q;
				opb = 64'd3125;
			end
			SP_E1: begin
				opa = p9;
				opb = qs;
			end
			SP_E2: begin
				opa = tmp_q;
				opb = qs;
			end
			SP_F: begin
				opa = p8;
				opb = q_q;
			end
			SH_M: begin
				opa = h5;
				opb = sx32(hx);
			end
			SH_B0: begin
				opa = sx32(hx);
				opb = h6;
			end
			SH_C0: begin
				opa = sx32(hx);
				opb = h3;
			end
			SH_B1: begin
				opa = sx32(hb_q);
				opb = sx32(hc_q);
			end
			SH_B2: begin
				opa = sx32(hb_q);
				opb = h2;
			end
			SH_V: begin
				opa = sx32(ha_q);
				opb = sx32(hb_q);
			end
			SH_EE: begin
				opa = sx32(he_q);
				opb = sx32(he_q);
			end
			SH_E1: begin
				opa = sx32(he_q);
				opb = h1;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase

		res_s = $signed(mul_res);
		r32   = $signed(mul_res[31:0]);
		a_nx  = res_s >>> 33;
		f_v   = res_s >>> 19;
		s_v   = q_q + e_q + f_v;
		pf    = (s_v >>> 8) + $signed(p7 << 4);
		if (pf > 64'sd2147483647) begin
			sat32 = 32'sh7fff_ffff;
		end else if (pf < -64'sd2147483648) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = pf[31:0];
		end

		a32   = $signed({2'b00, adc_h_q, 14'b0}) - $signed({h4[11:0], 20'b0})
			- r32 + 32'sd16384;
		he_nx = r32 >>> 4;
		v32   = hv_q - he_nx;
		if (v32 < 0) begin
			hum_nx = '0;
		end else if (v32 > 32'sd419430400) begin
			hum_nx = 17'd102400;
		end else begin
			hum_nx = v32[28:12];
		end

		tf_e    = {{3{t_fine_q[23]}}, t_fine_q};
		tf5     = (tf_e <<< 2) + tf_e + 27'sd128;
		temp_nx = {{13{tf5[26]}}, tf5[26:8]};
	end

	assign mul_start = (st_q == ST_ISSUE);
	assign pop_ready = (st_q == ST_IDLE);
	assign out_load  = (st_q == ST_DONE) && (!out_valid_q || out_ready);

	esc_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (opa),
		.b     (opb),
		.done  (mul_done),
		.res   (mul_res)
	);

	esc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (num_q),
		.den   (a_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= SP_XX;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			t_fine_q    <= '0;
			adc_p_q     <= '0;
			adc_h_q     <= '0;
			xx_q        <= '0;
			b_q         <= '0;
			tmp_q       <= '0;
			num_q       <= '0;
			a_q         <= '0;
			q_q         <= '0;
			e_q         <= '0;
			pres_q      <= '0;
			pvalid_q    <= 1'b0;
			ha_q        <= '0;
			hb_q        <= '0;
			hc_q        <= '0;
			hv_q        <= '0;
			he_q        <= '0;
			hum_q       <= '0;
			out_temp_q  <= '0;
			out_pres_q  <= '0;
			out_hum_q   <= '0;
			out_pvalid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_temp_q   <= temp_nx;
				out_pres_q   <= pres_q;
				out_hum_q    <= hum_q;
				out_pvalid_q <= pvalid_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (pop_valid) begin
						t_fine_q <= pop_item.t_fine;
						adc_p_q  <= pop_item.adc_p;
						adc_h_q  <= pop_item.adc_h;
						pres_q   <= '0;
						pvalid_q <= 1'b0;
						step_q   <= SP_XX;
						st_q     <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						st_q <= ST_ISSUE;
						case (step_q)
							SP_XX: begin
								xx_q   <= mul_res;
								step_q <= SP_B6;
							end
							SP_B6: begin
								b_q    <= mul_res + (p4 << 35);
								step_q <= SP_X5;
							end
							SP_X5: begin
								b_q    <= b_q + (mul_res << 17);
								step_q <= SP_X3;
							end
							SP_X3: begin
								tmp_q  <= res_s >>> 8;
								step_q <= SP_X2;
							end
							SP_X2: begin
								tmp_q  <= tmp_q + (mul_res << 12);
								step_q <= SP_A;
							end
							SP_A: begin
								a_q    <= a_nx;
								step_q <= (a_nx == 64'sd0) ? SH_M : SP_NUM;
							end
							SP_NUM: begin
								num_q       <= mul_res;
								div_start_q <= 1'b1;
								st_q        <= ST_DIV;
							end
							SP_E1: begin
								tmp_q  <= mul_res;
								step_q <= SP_E2;
							end
							SP_E2: begin
								e_q    <= res_s >>> 25;
								step_q <= SP_F;
							end
							SP_F: begin
								pres_q   <= sat32;
								pvalid_q <= 1'b1;
								step_q   <= SH_M;
							end
							SH_M: begin
								ha_q   <= a32 >>> 15;
								step_q <= SH_B0;
							end
							SH_B0: begin
								hb_q   <= r32 >>> 10;
								step_q <= SH_C0;
							end
							SH_C0: begin
								hc_q   <= (r32 >>> 11) + 32'sd32768;
								step_q <= SH_B1;
							end
							SH_B1: begin
								hb_q   <= (r32 >>> 10) + 32'sd2097152;
								step_q <= SH_B2;
							end
							SH_B2: begin
								hb_q   <= (r32 + 32'sd8192) >>> 14;
								step_q <= SH_V;
							end
							SH_V: begin
								hv_q   <= r32;
								he_q   <= r32 >>> 15;
								step_q <= SH_EE;
							end
							SH_EE: begin
								he_q   <= r32 >>> 7;
								step_q <= SH_E1;
							end
							SH_E1: begin
								hum_q <= hum_nx;
								st_q  <= ST_DONE;
							end
							default: begin
								st_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						q_q    <= $signed(div_quo);
						step_q <= SP_E1;
						st_q   <= ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = out_temp_q;
	assign pressure_q24_8    = out_pres_q;
	assign humidity_q22_10   = out_hum_q;
	assign pressure_valid    = out_pvalid_q;

	a_pres_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_pvalid_q) |-> (out_pres_q == 32'sd0))
		else $error("pressure not zero on a zero divisor");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_hum_q <= 17'd102400))
		else $error("humidity above full scale");

	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (st_q == ST_MUL))
		else $error("multiplier finished outside of its wait state");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV))
		else $error("divider finished outside of its wait state");

endmodule
`default_nettype wire

[src/env_sensor_compensation.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples
// using factory trim coefficients held in configuration registers.
// ----------------------------------------------------------------------------
//  Channel  Signals                                   Transfer
//  in       in_valid/in_ready, raw_* fields           valid & ready
//  out      out_valid/out_ready, result fields        valid & ready
//  cfg      cfg_we, cfg_index, cfg_data               cfg_we high
//
// The front pipeline forms the fine temperature and takes a new sample every
// cycle while the queue has room or its last stage is empty. The back part
// works on one sample at a time: eighteen passes through the shared
// multiplier (fourteen passes without a pressure divisor), a run of the
// 64-step divider, and an idle and a done state to take the sample and to
// hand over the result. A finished result waits in the output register while
// the next sample is worked on. Reset clears the trims and all control state.
// ----------------------------------------------------------------------------
module env_sensor_compensation #(
	parameter int unsigned QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [19:0]                        raw_pressure,
	input  wire logic [19:0]                        raw_temperature,
	input  wire logic [15:0]                        raw_humidity,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [31:0]                      temperature_centi,
	output logic signed [31:0]                      pressure_q24_8,
	output logic [16:0]                             humidity_q22_10,
	output logic                                    pressure_valid,
	input  wire logic                               cfg_we,
	input  wire logic [esc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [esc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [47:0] temp_trim_q;
	logic [63:0] press_trim_low_q, press_trim_high_q, hum_trim_q;
	logic [15:0] press_trim_last_q;

	logic               push_valid, push_ready, pop_valid, pop_ready;
	esc_pkg::esc_item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q       <= '0;
			press_trim_low_q  <= '0;
			press_trim_high_q <= '0;
			press_trim_last_q <= '0;
			hum_trim_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				esc_pkg::CFG_TEMP_TRIM:       temp_trim_q       <= cfg_data[47:0];
				esc_pkg::CFG_PRESS_TRIM_LOW:  press_trim_low_q  <= cfg_data;
				esc_pkg::CFG_PRESS_TRIM_HIGH: press_trim_high_q <= cfg_data;
				esc_pkg::CFG_PRESS_TRIM_LAST: press_trim_last_q <= cfg_data[15:0];
				esc_pkg::CFG_HUM_TRIM:        hum_trim_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	esc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_pressure   (raw_pressure),
		.raw_temperature(raw_temperature),
		.raw_humidity   (raw_humidity),
		.temp_trim      (temp_trim_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	esc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	esc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_valid        (pop_valid),
		.pop_ready        (pop_ready),
		.pop_item         (pop_item),
		.press_trim_low   (press_trim_low_q),
		.press_trim_high  (press_trim_high_q),
		.press_trim_last  (press_trim_last_q),
		.hum_trim         (hum_trim_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.temperature_centi(temperature_centi),
		.pressure_q24_8   (pressure_q24_8),
		.humidity_q22_10  (humidity_q22_10),
		.pressure_valid   (pressure_valid)
	);

endmodule
`default_nettype wire

[dv/tb_env_sensor_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// Self-checking bench for the sensor compensation block. A directed table of
// raw samples is followed by random samples under a series of trim settings.
// The expected reading of each accepted sample comes from a bench-side integer
// model or a typed table row, and every output transfer is compared in order.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation;

	localparam logic [esc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
	localparam longint S64_MIN = 64'sh8000000000000000;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int unsigned RANDOM_SAMPLES = 900;

	typedef struct packed {
		logic signed [31:0] temp;
		logic signed [31:0] press;
		logic [16:0]        hum;
		logic               press_ok;
	} reading_t;

	typedef enum int {
		TRIM_ZERO, TRIM_TYPICAL, TRIM_ALL_ONES, TRIM_MIN, TRIM_RANDOM, TRIM_NO_DIVISOR,
		TRIM_NEAR_TYPICAL
	} trim_set_t;

	typedef struct {
		logic [19:0] p;
		logic [19:0] t;
		logic [15:0] h;
		trim_set_t   set;
		bit          typed;
		reading_t    want;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [19:0] raw_pressure = '0;
	logic [19:0] raw_temperature = '0;
	logic [15:0] raw_humidity = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] temperature_centi;
	logic signed [31:0] pressure_q24_8;
	logic [16:0] humidity_q22_10;
	logic pressure_valid;
	logic cfg_we = 1'b0;
	logic [esc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [esc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [47:0] temp_trim;
	logic [63:0] press_trim_low;
	logic [63:0] press_trim_high;
	logic [15:0] press_trim_last;
	logic [63:0] hum_trim;

	reading_t pending_readings[$];
	int unsigned mismatches = 0;
	bit throttle = 1'b1;
	bit long_hold_req = 1'b0;
	int unsigned hold_left = 0;

	env_sensor_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.raw_humidity(raw_humidity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature_centi(temperature_centi),
		.pressure_q24_8(pressure_q24_8),
		.humidity_q22_10(humidity_q22_10),
		.pressure_valid(pressure_valid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
		longint adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint d, va, vb, t_fine, x, b, a, q, num, e, f, pv;
		int h1, h2, h3, h4, h5, h6, adc_h, hx, ha, hb, hc, hv, he;
		reading_t r;
		adc_p = longint'(rp);
		adc_t = longint'(rt);
		adc_h = int'(rh);
		t1 = longint'(temp_trim[15:0]);
		t2 = longint'($signed(temp_trim[31:16]));
		t3 = longint'($signed(temp_trim[47:32]));
		p1 = longint'(press_trim_low[15:0]);
		p2 = longint'($signed(press_trim_low[31:16]));
		p3 = longint'($signed(press_trim_low[47:32]));
		p4 = longint'($signed(press_trim_low[63:48]));
		p5 = longint'($signed(press_trim_high[15:0]));
		p6 = longint'($signed(press_trim_high[31:16]));
		p7 = longint'($signed(press_trim_high[47:32]));
		p8 = longint'($signed(press_trim_high[63:48]));
		p9 = longint'($signed(press_trim_last));
		h1 = int'(hum_trim[7:0]);
		h2 = int'($signed(hum_trim[23:8]));
		h3 = int'(hum_trim[31:24]);
		h4 = int'($signed(hum_trim[43:32]));
		h5 = int'($signed(hum_trim[55:44]));
		h6 = int'($signed(hum_trim[63:56]));

		d = (adc_t >>> 4) - t1;
		va = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
		vb = (((d * d) >>> 12) * t3) >>> 14;
		t_fine = va + vb;
		r.temp = 32'((t_fine * 5 + 128) >>> 8);

		x = t_fine - 128000;
		b = x * x * p6;
		b = b + ((x * p5) << 17);
		b = b + (p4 << 35);
		a = ((x * x * p3) >>> 8) + ((x * p2) << 12);
		a = (((longint'(1) << 47) + a) * p1) >>> 33;
		r.press = '0;
		r.press_ok = 1'b0;
		if (a != 0) begin
			pv = 1048576 - adc_p;
			num = ((pv << 31) - b) * 3125;
			if (num == S64_MIN && a == -1) begin
				q = S64_MIN;
			end else begin
				q = num / a;
			end
			e = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
			f = (p8 * q) >>> 19;
			pv = ((q + e + f) >>> 8) + (p7 << 4);
			if (pv > S32_MAX) pv = S32_MAX;
			if (pv < S32_MIN) pv = S32_MIN;
			r.press = 32'(pv);
			r.press_ok = 1'b1;
		end

		hx = int'(t_fine - 76800);
		ha = adc_h * 16384 - h4 * 1048576 - h5 * hx + 16384;
		ha = ha >>> 15;
		hb = (hx * h6) >>> 10;
		hc = ((hx * h3) >>> 11) + 32768;
		hb = ((hb * hc) >>> 10) + 2097152;
		hb = (hb * h2 + 8192) >>> 14;
		hv = ha * hb;
		he = hv >>> 15;
		he = (he * he) >>> 7;
		he = (he * h1) >>> 4;
		hv = hv - he;
		if (hv < 0) hv = 0;
		if (hv > 419430400) hv = 419430400;
		r.hum = 17'(hv >>> 12);
		return r;
	endfunction

	task automatic write_trim(logic [esc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			esc_pkg::CFG_TEMP_TRIM:       temp_trim = value[47:0];
			esc_pkg::CFG_PRESS_TRIM_LOW:  press_trim_low = value;
			esc_pkg::CFG_PRESS_TRIM_HIGH: press_trim_high = value;
			esc_pkg::CFG_PRESS_TRIM_LAST: press_trim_last = value[15:0];
			esc_pkg::CFG_HUM_TRIM:        hum_trim = value;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic load_trims(trim_set_t set);
		logic [63:0] tt, pl, ph, pz, ht;
		wait (pending_readings.size() == 0);
		repeat (4) @(posedge clk);
		case (set)
			TRIM_TYPICAL, TRIM_NEAR_TYPICAL: begin
				tt = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
				pl = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
				ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
				pz = 64'd6000;
				ht = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};
				if (set == TRIM_NEAR_TYPICAL) begin
					tt[15:0] = tt[15:0] + 16'($urandom_range(4000)) - 16'd2000;
					pl[15:0] = pl[15:0] + 16'($urandom_range(4000)) - 16'd2000;
					ph[31:16] = 16'($urandom_range(40)) - 16'd20;
					ht[7:0] = 8'($urandom);
					ht[31:24] = 8'($urandom);
					ht[63:56] = 8'($urandom);
				end
			end
			TRIM_ALL_ONES: begin
				tt = '1; pl = '1; ph = '1; pz = '1; ht = '1;
			end
			TRIM_MIN: begin
				tt = {16'h0000, 16'h8000, 16'h8000, 16'hFFFF};
				pl = {16'h8000, 16'h8000, 16'h8000, 16'hFFFF};
				ph = {4{16'h8000}};
				pz = 64'h8000;
				ht = {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF};
			end
			TRIM_RANDOM, TRIM_NO_DIVISOR: begin
				tt = rand64(); pl = rand64(); ph = rand64(); pz = rand64(); ht = rand64();
				if (set == TRIM_NO_DIVISOR) pl[15:0] = '0;
			end
			default: begin
				tt = '0; pl = '0; ph = '0; pz = '0; ht = '0;
			end
		endcase
		write_trim(esc_pkg::CFG_TEMP_TRIM, tt);
		write_trim(esc_pkg::CFG_PRESS_TRIM_LOW, pl);
		write_trim(esc_pkg::CFG_PRESS_TRIM_HIGH, ph);
		write_trim(esc_pkg::CFG_PRESS_TRIM_LAST, pz);
		write_trim(esc_pkg::CFG_HUM_TRIM, ht);
		write_trim(CFG_UNMAPPED, rand64());
	endtask

	// Called right after a rising edge; returns at the edge of the transfer.
	task automatic send_sample(logic [19:0] p, logic [19:0] t, logic [15:0] h,
			bit typed, reading_t want);
		while (throttle && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= p;
		raw_temperature <= t;
		raw_humidity <= h;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(typed ? want : compensate(p, t, h));
	endtask

	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !throttle || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		reading_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{temperature_centi, pressure_q24_8, humidity_q22_10, pressure_valid};
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %p", got);
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("wrong reading: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("env_sensor_compensation: mismatch");
		$finish;
	end

	initial begin
		sample_row_t rows[$];
		trim_set_t loaded;
		trim_set_t phases[7];
		logic [19:0] p, t;
		logic [15:0] h;
		reading_t none;
		none = '0;
		temp_trim = '0;
		press_trim_low = '0;
		press_trim_high = '0;
		press_trim_last = '0;
		hum_trim = '0;
		rows = '{
			'{20'd0, 20'd0, 16'd0, TRIM_ZERO, 1'b1, none},
			'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, TRIM_ZERO, 1'b1, none},
			'{20'd415148, 20'd519888, 16'd30000, TRIM_ZERO, 1'b1, none},
			'{20'd415148, 20'd519888, 16'd30000, TRIM_TYPICAL, 1'b0, none},
			'{20'd0, 20'd0, 16'd0, TRIM_TYPICAL, 1'b0, none},
			'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, TRIM_TYPICAL, 1'b0, none},
			'{20'hFFFFF, 20'd519888, 16'd0, TRIM_TYPICAL, 1'b0, none},
			'{20'd0, 20'd519888, 16'hFFFF, TRIM_TYPICAL, 1'b0, none},
			'{20'd300000, 20'd400000, 16'd50000, TRIM_TYPICAL, 1'b0, none},
			'{20'd0, 20'd0, 16'd0, TRIM_ALL_ONES, 1'b0, none},
			'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, TRIM_ALL_ONES, 1'b0, none},
			'{20'h55555, 20'hAAAAA, 16'h5555, TRIM_ALL_ONES, 1'b0, none},
			'{20'd0, 20'd0, 16'd0, TRIM_MIN, 1'b0, none},
			'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, TRIM_MIN, 1'b0, none},
			'{20'hAAAAA, 20'h55555, 16'hAAAA, TRIM_MIN, 1'b0, none},
			'{20'd0, 20'd519888, 16'd30000, TRIM_NO_DIVISOR, 1'b0, none},
			'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, TRIM_NO_DIVISOR, 1'b0, none}
		};
		phases = '{TRIM_NEAR_TYPICAL, TRIM_TYPICAL, TRIM_RANDOM, TRIM_NEAR_TYPICAL,
			TRIM_NO_DIVISOR, TRIM_RANDOM, TRIM_NEAR_TYPICAL};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		loaded = TRIM_ZERO;
		foreach (rows[i]) begin
			if (rows[i].set != loaded) begin
				in_valid <= 1'b0;
				load_trims(rows[i].set);
				loaded = rows[i].set;
			end
			send_sample(rows[i].p, rows[i].t, rows[i].h, rows[i].typed, rows[i].want);
		end

		foreach (phases[k]) begin
			in_valid <= 1'b0;
			load_trims(phases[k]);
			throttle = (k != 1);
			for (int n = 0; n < RANDOM_SAMPLES / 7; n++) begin
				if (k == 3 && n == 20) long_hold_req = 1'b1;
				if ($urandom_range(99) < 60) begin
					p = 20'($urandom_range(500000, 250000));
					t = 20'($urandom_range(600000, 400000));
					h = 16'($urandom_range(50000, 20000));
				end else begin
					p = 20'($urandom);
					t = 20'($urandom);
					h = 16'($urandom);
				end
				send_sample(p, t, h, 1'b0, none);
			end
		end
		in_valid <= 1'b0;
		wait (pending_readings.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("env_sensor_compensation: match");
		end else begin
			$display("env_sensor_compensation: mismatch");
		end
		$finish;
	end

endmodule

[env_sensor_compensation.f]
src/esc_pkg.sv
src/esc_front.sv
src/esc_fifo.sv
src/esc_mul.sv
src/esc_div.sv
src/esc_back.sv
src/env_sensor_compensation.sv
dv/tb_env_sensor_compensation.sv
